/* rtl/sm83_pkg.sv */
// sm83_pkg: shared constants and types for the sm83 execute core
// depends on nothing
`default_nettype none
package sm83_pkg;
    localparam int unsigned InWidth  = 32;
    localparam int unsigned OutWidth = 128;
    localparam logic [7:0] OpHalt   = 8'h76;
    localparam logic [7:0] OpJp     = 8'hC3;
    localparam logic [7:0] OpJpHl   = 8'hE9;
    localparam logic [2:0] RegF     = 3'd6;
    localparam logic [2:0] RegA     = 3'd7;
    localparam logic [2:0] RegMemHl = 3'd6;
    localparam logic [2:0] AluAdd = 3'd0;
    localparam logic [2:0] AluAdc = 3'd1;
    localparam logic [2:0] AluSub = 3'd2;
    localparam logic [2:0] AluSbc = 3'd3;
    localparam logic [2:0] AluAnd = 3'd4;
    localparam logic [2:0] AluXor = 3'd5;
    localparam logic [2:0] AluOr  = 3'd6;
    localparam logic [2:0] AluCp  = 3'd7;

    typedef struct packed {
        logic [7:0] a;
        logic [3:0] f;   // z n h c
    } alu_res_t;
endpackage
`default_nettype wire

/* rtl/sm83_load_alu_jump_execute_core.sv */
// sm83_load_alu_jump_execute_core: executes one instruction per item
// depends on sm83_pkg
`default_nettype none
// One instruction item is accepted per cycle while the result register is free or being
// taken; its result appears in the next cycle. The register file, PC and SP update in the
// accept cycle so the following item sees them at once. Rate: one item per cycle, set by
// the one decode and ALU pass into the result register. Reset clears all but m_data_reg.
module sm83_load_alu_jump_execute_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sm83_pkg::InWidth-1:0]     s_tdata,  // opcode, imm_low, imm_high,
                                                            // mem_rdata
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sm83_pkg::OutWidth-1:0]         m_tdata   // next_pc, mem_write, mem_addr,
                                                            // mem_wdata, acc_value,
                                                            // flag_value, bc, de, hl, sp,
                                                            // unknown_opcode, 6 zero bits
);
    logic [7:0]  rf_reg [8];
    logic [15:0] pc_reg, sp_reg;
    logic        m_valid_reg;
    logic [sm83_pkg::OutWidth-1:0] m_data_reg;

    logic [7:0] op, lo, hi, md;
    logic [2:0] y, z;
    logic [1:0] p;
    logic       q;
    assign op = s_tdata[7:0];
    assign lo = s_tdata[15:8];
    assign hi = s_tdata[23:16];
    assign md = s_tdata[31:24];
    assign y = op[5:3];
    assign z = op[2:0];
    assign p = y[2:1];
    assign q = y[0];

    assign s_tready = !m_valid_reg || m_tready;
    logic accept;
    assign accept = s_tvalid && s_tready;

    // alu for 8-bit operations
    function automatic sm83_pkg::alu_res_t alu8(input logic [2:0] o, input logic [7:0] a,
                                               input logic [7:0] v, input logic c);
        sm83_pkg::alu_res_t r;
        logic ci;
        logic [8:0] s;
        logic [4:0] hs;
        ci = 1'b0;
        s = '0;
        hs = '0;
        r.a = a;
        r.f = '0;
        case (o)
            sm83_pkg::AluAdd, sm83_pkg::AluAdc: begin
                ci = (o == sm83_pkg::AluAdc) ? c : 1'b0;
                s = {1'b0, a} + {1'b0, v} + {8'd0, ci};
                hs = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci};
                r.a = s[7:0];
                r.f = {1'b0, 1'b0, hs[4], s[8]};
            end
            sm83_pkg::AluAnd: begin r.a = a & v; r.f = 4'b0010; end
            sm83_pkg::AluXor: begin r.a = a ^ v; r.f = 4'b0000; end
            sm83_pkg::AluOr:  begin r.a = a | v; r.f = 4'b0000; end
            default: begin
                ci = (o == sm83_pkg::AluSbc) ? c : 1'b0;
                s = {1'b0, a} - {1'b0, v} - {8'd0, ci};
                hs = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci};
                r.f = {1'b0, 1'b1, hs[4], s[8]};
                r.a = (o == sm83_pkg::AluCp) ? a : s[7:0];
            end
        endcase
        r.f[3] = (o == sm83_pkg::AluCp) ? (s[7:0] == 8'd0) :
                 (((o == sm83_pkg::AluAdd) || (o == sm83_pkg::AluAdc) || (o == sm83_pkg::AluSub)
                   || (o == sm83_pkg::AluSbc)) ? (s[7:0] == 8'd0) : (r.a == 8'd0));
        return r;
    endfunction

    // condition decode
    function automatic logic cond_met(input logic [1:0] cc, input logic fz, input logic fc);
        case (cc)
            2'd0:    return !fz;
            2'd1:    return fz;
            2'd2:    return !fc;
            default: return fc;
        endcase
    endfunction

    logic [7:0]  rf_next [8];
    logic [15:0] pc_next, sp_next;
    logic [15:0] bc, de, hl, rr_p, d16, rel, target, wa;
    logic [7:0]  wd, fcur, inc_v, inc_r, reg_z, reg_y;
    logic [3:0]  fl;
    logic [1:0]  len;
    logic        jmp, wr, unk;
    logic [16:0] add16;
    logic [12:0] add12;
    sm83_pkg::alu_res_t ar;

    assign bc = {rf_reg[0], rf_reg[1]};
    assign de = {rf_reg[2], rf_reg[3]};
    assign hl = {rf_reg[4], rf_reg[5]};
    assign d16 = {hi, lo};
    assign fcur = rf_reg[sm83_pkg::RegF];
    assign rel = pc_reg + 16'd2 + {{8{lo[7]}}, lo};
    assign reg_z = (z == sm83_pkg::RegMemHl) ? md : rf_reg[z];
    assign reg_y = (y == sm83_pkg::RegMemHl) ? md : rf_reg[y];

    always_comb begin
        case (p)
            2'd0: rr_p = bc;
            2'd1: rr_p = de;
            2'd2: rr_p = hl;
            default: rr_p = sp_reg;
        endcase
    end

    // instruction decode and execute
    always_comb begin
        for (int i = 0; i < 8; i++) rf_next[i] = rf_reg[i];
        sp_next = sp_reg;
        fl = fcur[7:4];
        len = 2'd1; jmp = 1'b0; target = '0; wr = 1'b0; wa = '0; wd = '0; unk = 1'b0;
        add16 = {1'b0, hl} + {1'b0, rr_p};
        add12 = {1'b0, hl[11:0]} + {1'b0, rr_p[11:0]};
        inc_v = reg_y;
        inc_r = (z == 3'd4) ? inc_v + 8'd1 : inc_v - 8'd1;
        ar = alu8(y, rf_reg[sm83_pkg::RegA], (op[7:6] == 2'd2) ? reg_z : lo, fcur[4]);
        case (op[7:6])
            2'd0: begin
                case (z)
                    3'd0: begin
                        if (y == 3'd3) begin
                            len = 2'd2; jmp = 1'b1; target = rel;
                        end else if (y[2]) begin
                            len = 2'd2;
                            jmp = cond_met(y[1:0], fcur[7], fcur[4]); target = rel;
                        end else if (y != 3'd0) begin
                            unk = 1'b1;
                        end
                    end
                    3'd1: begin
                        if (!q) begin
                            len = 2'd3;
                            if (p == 2'd3) sp_next = d16;
                            else begin
                                rf_next[{p, 1'b0}] = hi; rf_next[{p, 1'b1}] = lo;
                            end
                        end else begin
                            fl = {fcur[7], 1'b0, add12[12], add16[16]};
                            rf_next[4] = add16[15:8]; rf_next[5] = add16[7:0];
                        end
                    end
                    3'd2: begin
                        wa = (p == 2'd0) ? bc : (p == 2'd1) ? de : hl;
                        if (!q) begin
                            wr = 1'b1; wd = rf_reg[sm83_pkg::RegA];
                        end else rf_next[sm83_pkg::RegA] = md;
                        if (p == 2'd2) {rf_next[4], rf_next[5]} = hl + 16'd1;
                        if (p == 2'd3) {rf_next[4], rf_next[5]} = hl - 16'd1;
                        if (q) wa = '0;
                    end
                    3'd3: begin
                        if (p == 2'd3) sp_next = q ? sp_reg - 16'd1 : sp_reg + 16'd1;
                        else {rf_next[{p, 1'b0}], rf_next[{p, 1'b1}]} =
                            q ? rr_p - 16'd1 : rr_p + 16'd1;
                    end
                    3'd4, 3'd5: begin
                        fl = {inc_r == 8'd0, z == 3'd5,
                              (z == 3'd4) ? (inc_v[3:0] == 4'hF) : (inc_v[3:0] == 4'h0),
                              fcur[4]};
                        if (y == sm83_pkg::RegMemHl) begin
                            wr = 1'b1; wa = hl; wd = inc_r;
                        end else rf_next[y] = inc_r;
                    end
                    3'd6: begin
                        len = 2'd2;
                        if (y == sm83_pkg::RegMemHl) begin
                            wr = 1'b1; wa = hl; wd = lo;
                        end else rf_next[y] = lo;
                    end
                    default: unk = 1'b1;
                endcase
            end
            2'd1: begin
                if (op == sm83_pkg::OpHalt) unk = 1'b1;
                else if (y == sm83_pkg::RegMemHl) begin
                    wr = 1'b1; wa = hl; wd = reg_z;
                end else rf_next[y] = reg_z;
            end
            2'd2: begin
                rf_next[sm83_pkg::RegA] = ar.a; fl = ar.f;
            end
            default: begin
                if (z == 3'd2 && !y[2]) begin
                    len = 2'd3; jmp = cond_met(y[1:0], fcur[7], fcur[4]); target = d16;
                end else if (op == sm83_pkg::OpJp) begin
                    len = 2'd3; jmp = 1'b1; target = d16;
                end else if (op == sm83_pkg::OpJpHl) begin
                    jmp = 1'b1; target = hl;
                end else if (z == 3'd6) begin
                    len = 2'd2; rf_next[sm83_pkg::RegA] = ar.a; fl = ar.f;
                end else unk = 1'b1;
            end
        endcase
        rf_next[sm83_pkg::RegF] = {fl, 4'h0};
        pc_next = jmp ? target : pc_reg + {14'd0, len};
    end

    // architectural state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) rf_reg[i] <= '0;
            pc_reg <= '0;
            sp_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                for (int i = 0; i < 8; i++) rf_reg[i] <= rf_next[i];
                pc_reg <= pc_next;
                sp_reg <= sp_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {6'd0, unk, sp_next,
                           rf_next[4], rf_next[5], rf_next[2], rf_next[3],
                           rf_next[0], rf_next[1],
                           rf_next[sm83_pkg::RegF], rf_next[sm83_pkg::RegA],
                           wr ? wd : 8'd0, wr ? wa : 16'd0, wr, pc_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    a_flag_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_reg[sm83_pkg::RegF][3:0] == 4'h0) else $error("flag low nibble set");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid) else $error("result lost");
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[40:17] == 24'd0))
        else $error("write fields not cleared");
endmodule
`default_nettype wire

/* bench/testbench.sv */
// testbench: self-checking bench for sm83_load_alu_jump_execute_core
// depends on sm83_pkg and the core; predicts each instruction result in-bench
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        mem_write;
        logic [15:0] mem_addr;
        logic [7:0]  mem_wdata;
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic        unknown;
    } exec_res_t;

    localparam int WatchLimit = 20000;
    localparam logic [7:0] FlagZ = 8'h80;
    localparam logic [7:0] FlagN = 8'h40;
    localparam logic [7:0] FlagH = 8'h20;
    localparam logic [7:0] FlagC = 8'h10;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [sm83_pkg::InWidth-1:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [sm83_pkg::OutWidth-1:0] m_tdata;

    // predictor state
    logic [7:0]  regs [8];
    logic [15:0] pc_q, sp_q;

    logic [31:0] instr_queue [$];
    exec_res_t   expected_results [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          hold_off = 0;
    bit          stim_done = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    sm83_load_alu_jump_execute_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [15:0] pair_get(input logic [1:0] p);
        if (p == 2'd3) return sp_q;
        return {regs[2*p], regs[2*p+1]};
    endfunction

    function automatic void pair_set(input logic [1:0] p, input logic [15:0] v);
        if (p == 2'd3) sp_q = v;
        else begin
            regs[2*p] = v[15:8];
            regs[2*p+1] = v[7:0];
        end
    endfunction

    function automatic bit cond_true(input logic [1:0] cc, input logic [7:0] f);
        case (cc)
            2'd0: return (f & FlagZ) == 8'd0;
            2'd1: return (f & FlagZ) != 8'd0;
            2'd2: return (f & FlagC) == 8'd0;
            default: return (f & FlagC) != 8'd0;
        endcase
    endfunction

    // 8-bit alu on A, returns new flags
    function automatic logic [7:0] alu_exec(input logic [2:0] op, input logic [7:0] v,
                                            input logic [7:0] f);
        logic [8:0] a, ci, s;
        logic [7:0] r, nf;
        a = {1'b0, regs[sm83_pkg::RegA]};
        ci = ((f & FlagC) != 8'd0) ? 9'd1 : 9'd0;
        nf = '0;
        r = '0;
        case (op)
            sm83_pkg::AluAdd, sm83_pkg::AluAdc: begin
                if (op == sm83_pkg::AluAdd) ci = 9'd0;
                s = a + {1'b0, v} + ci;
                r = s[7:0];
                if ({5'b0, a[3:0]} + {5'b0, v[3:0]} + ci > 9'h0F) nf |= FlagH;
                if (s[8]) nf |= FlagC;
            end
            sm83_pkg::AluAnd: begin r = a[7:0] & v; nf = FlagH; end
            sm83_pkg::AluXor: r = a[7:0] ^ v;
            sm83_pkg::AluOr:  r = a[7:0] | v;
            default: begin
                if (op != sm83_pkg::AluSbc) ci = 9'd0;
                r = a[7:0] - v - ci[7:0];
                nf = FlagN;
                if ({5'b0, a[3:0]} < {5'b0, v[3:0]} + ci) nf |= FlagH;
                if (a < {1'b0, v} + ci) nf |= FlagC;
            end
        endcase
        if (r == 8'd0) nf |= FlagZ;
        if (op != sm83_pkg::AluCp) regs[sm83_pkg::RegA] = r;
        return nf;
    endfunction

    function automatic exec_res_t execute_instr(input logic [31:0] item);
        logic [7:0] op, lo, hi, md, f, v, r;
        logic [2:0] y, z;
        logic [1:0] p;
        logic q, jump;
        logic [15:0] len, target, hl, d16, rel, addr, v16;
        logic [16:0] s17;
        exec_res_t res;
        op = item[7:0]; lo = item[15:8]; hi = item[23:16]; md = item[31:24];
        y = op[5:3]; z = op[2:0]; p = y[2:1]; q = y[0];
        res = '0;
        len = 16'd1; jump = 1'b0; target = 16'd0;
        hl = pair_get(2'd2); d16 = {hi, lo};
        f = regs[sm83_pkg::RegF] & 8'hF0;
        rel = pc_q + 16'd2 + {{8{lo[7]}}, lo};
        case (op[7:6])
            2'd0: begin
                case (z)
                    3'd0: begin
                        if (y == 3'd3) begin len = 16'd2; jump = 1'b1; target = rel; end
                        else if (y >= 3'd4) begin
                            len = 16'd2;
                            if (cond_true(y[1:0], f)) begin jump = 1'b1; target = rel; end
                        end else if (y != 3'd0) res.unknown = 1'b1;
                    end
                    3'd1: begin
                        if (!q) begin pair_set(p, d16); len = 16'd3; end
                        else begin
                            v16 = pair_get(p);
                            s17 = {1'b0, hl} + {1'b0, v16};
                            f &= FlagZ;
                            if ({1'b0, hl[11:0]} + {1'b0, v16[11:0]} > 13'hFFF) f |= FlagH;
                            if (s17[16]) f |= FlagC;
                            pair_set(2'd2, s17[15:0]);
                        end
                    end
                    3'd2: begin
                        addr = (p == 2'd0) ? pair_get(2'd0) : (p == 2'd1) ? pair_get(2'd1) : hl;
                        if (!q) begin
                            res.mem_write = 1'b1; res.mem_addr = addr;
                            res.mem_wdata = regs[sm83_pkg::RegA];
                        end else regs[sm83_pkg::RegA] = md;
                        if (p == 2'd2) pair_set(2'd2, hl + 16'd1);
                        if (p == 2'd3) pair_set(2'd2, hl - 16'd1);
                    end
                    3'd3: pair_set(p, pair_get(p) + (q ? 16'hFFFF : 16'd1));
                    3'd4, 3'd5: begin
                        v = (y == sm83_pkg::RegMemHl) ? md : regs[y];
                        f &= FlagC;
                        if (z == 3'd4) begin
                            r = v + 8'd1;
                            if (v[3:0] == 4'hF) f |= FlagH;
                        end else begin
                            r = v - 8'd1;
                            f |= FlagN;
                            if (v[3:0] == 4'h0) f |= FlagH;
                        end
                        if (r == 8'd0) f |= FlagZ;
                        if (y == sm83_pkg::RegMemHl) begin
                            res.mem_write = 1'b1; res.mem_addr = hl; res.mem_wdata = r;
                        end else regs[y] = r;
                    end
                    3'd6: begin
                        len = 16'd2;
                        if (y == sm83_pkg::RegMemHl) begin
                            res.mem_write = 1'b1; res.mem_addr = hl; res.mem_wdata = lo;
                        end else regs[y] = lo;
                    end
                    default: res.unknown = 1'b1;
                endcase
            end
            2'd1: begin
                if (op == sm83_pkg::OpHalt) res.unknown = 1'b1;
                else begin
                    v = (z == sm83_pkg::RegMemHl) ? md : regs[z];
                    if (y == sm83_pkg::RegMemHl) begin
                        res.mem_write = 1'b1; res.mem_addr = hl; res.mem_wdata = v;
                    end else regs[y] = v;
                end
            end
            2'd2: f = alu_exec(y, (z == sm83_pkg::RegMemHl) ? md : regs[z], f);
            default: begin
                if (z == 3'd2 && y < 3'd4) begin
                    len = 16'd3;
                    if (cond_true(y[1:0], f)) begin jump = 1'b1; target = d16; end
                end else if (op == sm83_pkg::OpJp) begin
                    len = 16'd3; jump = 1'b1; target = d16;
                end else if (op == sm83_pkg::OpJpHl) begin
                    jump = 1'b1; target = hl;
                end else if (z == 3'd6) begin
                    len = 16'd2; f = alu_exec(y, lo, f);
                end else res.unknown = 1'b1;
            end
        endcase
        regs[sm83_pkg::RegF] = f & 8'hF0;
        pc_q = jump ? target : pc_q + len;
        res.next_pc = pc_q;
        res.acc = regs[sm83_pkg::RegA];
        res.flags = regs[sm83_pkg::RegF];
        res.bc = pair_get(2'd0);
        res.de = pair_get(2'd1);
        res.hl = pair_get(2'd2);
        res.sp = sp_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 50) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // opcode mix biased toward jumps, otherwise random opcodes, with random content
    function automatic logic [31:0] random_instr();
        logic [7:0] op;
        case ($urandom_range(0, 9))
            0: op = sm83_pkg::OpJp;
            1: op = {3'b001, ($urandom_range(0, 3) == 0) ? 2'b11 : 2'($urandom), 3'b000};
            2: op = {2'b11, 1'b0, 2'($urandom), 3'b010};
            3: op = sm83_pkg::OpJpHl;
            default: op = 8'($urandom);
        endcase
        return {8'($urandom), 8'($urandom), 8'($urandom), op};
    endfunction

    // stimulus: directed then random, with a drain pause and a receiver hold-off
    initial begin
        logic [7:0] dir_ops [$];
        logic [31:0] item;
        dir_ops = '{8'h00, 8'h76, 8'h10, 8'h01, 8'h11, 8'h21, 8'h31, 8'h09, 8'h39, 8'h02,
                    8'h22, 8'h32, 8'h2A, 8'h3A, 8'h34, 8'h35, 8'h36, 8'h18, 8'h20, 8'h38,
                    8'hCE, 8'hDE, 8'hE6, 8'hFE, 8'hE9};
        foreach (dir_ops[i]) begin
            item = {8'($urandom), (i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h80 : 8'hFF,
                    dir_ops[i]};
            instr_queue.push_back(item);
        end
        for (int i = 0; i < 256; i++)
            instr_queue.push_back({8'($urandom), 8'($urandom), 8'($urandom), 8'(i)});
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (instr_queue.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (3) @(posedge aclk);
        hold_off = 60;
        for (int i = 0; i < 550; i++) instr_queue.push_back(random_instr());
        wait (instr_queue.size() == 0 && !s_tvalid);
        stim_done = 1'b1;
    end

    task automatic item_drive();
        logic [31:0] item;
        item = instr_queue.pop_front();
        s_tdata <= item;
        s_tvalid <= 1'b1;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) s_tvalid <= 1'b0;
        else begin
            if (s_tvalid && s_tready) send_gap = pick_gap();
            if ((!s_tvalid || s_tready) ) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (instr_queue.size() > 0) begin
                    item_drive();
                end else s_tvalid <= 1'b0;
            end
        end
    end

    // predict at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (regs[i]) regs[i] = '0;
            pc_q = '0;
            sp_q = '0;
        end else if (s_tvalid && s_tready)
            expected_results.push_back(execute_instr(s_tdata));
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        exec_res_t got, want;
        if (m_tvalid && m_tready && aresetn) begin
            got = '{next_pc: m_tdata[15:0], mem_write: m_tdata[16], mem_addr: m_tdata[32:17],
                    mem_wdata: m_tdata[40:33], acc: m_tdata[48:41], flags: m_tdata[56:49],
                    bc: m_tdata[72:57], de: m_tdata[88:73], hl: m_tdata[104:89],
                    sp: m_tdata[120:105], unknown: m_tdata[121]};
            if (expected_results.size() == 0) begin
                $display("result item with no expectation");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.next_pc != want.next_pc)
                    report_mismatch("next_pc", got.next_pc, want.next_pc);
                if (got.mem_write != want.mem_write)
                    report_mismatch("mem_write", {15'd0, got.mem_write},
                                    {15'd0, want.mem_write});
                if (got.mem_addr != want.mem_addr)
                    report_mismatch("mem_addr", got.mem_addr, want.mem_addr);
                if (got.mem_wdata != want.mem_wdata)
                    report_mismatch("mem_wdata", {8'd0, got.mem_wdata},
                                    {8'd0, want.mem_wdata});
                if (got.acc != want.acc)
                    report_mismatch("acc", {8'd0, got.acc}, {8'd0, want.acc});
                if (got.flags != want.flags)
                    report_mismatch("flags", {8'd0, got.flags}, {8'd0, want.flags});
                if (got.bc != want.bc) report_mismatch("bc", got.bc, want.bc);
                if (got.de != want.de) report_mismatch("de", got.de, want.de);
                if (got.hl != want.hl) report_mismatch("hl", got.hl, want.hl);
                if (got.sp != want.sp) report_mismatch("sp", got.sp, want.sp);
                if (got.unknown != want.unknown)
                    report_mismatch("unknown", {15'd0, got.unknown}, {15'd0, want.unknown});
            end
        end
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (m_tvalid && m_tready) recv_gap = pick_gap();
        end
    end

    // watchdog and end of run
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0 && !m_tvalid)
            $display("RESULT: OK");
        else begin
            if (m_tvalid) $display("result item with no expectation");
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
